### src/ccs_pkg.sv
// shared types and constants for the chacha20 stream cipher
// no dependencies
package ccs_pkg;

   localparam int BlockBytes = 64;
   localparam int UsedWidth  = $clog2(BlockBytes) + 1;
   localparam int ByteIdxWidth = $clog2(BlockBytes);
   localparam int DoubleRounds = 10;
   localparam int RoundCntWidth = 5;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 64;

   localparam logic [CsrIdxWidth-1:0] REG_KEY0        = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_KEY1        = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_KEY2        = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_KEY3        = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_NONCE_LOW   = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_NONCE_HIGH  = 3'd5;
   localparam logic [CsrIdxWidth-1:0] REG_START_COUNT = 3'd6;

   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] SIGMA3 = 32'h6b206574;

   typedef logic [15:0][31:0] state_type;

   // controller to datapath
   typedef struct packed {
      logic load_init;    // latch init words and seed the working state
      logic round;        // apply one half round (column or diagonal)
      logic diag;         // 1 selects diagonal half round
      logic finish;       // add init to working state into keystream, bump counter
      logic restart;      // reload counter from start value
      logic take_byte;    // capture input byte and produce result
   } cmd_type;

   typedef struct packed {
      logic dummy_ok;
   } status_type;

   typedef struct packed {
      logic [7:0] data_in;
      logic       last_in;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       last_out;
   } rsp_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   // one quarter round on four words
   function automatic logic [127:0] quarter(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
      logic [31:0] a1, b1, c1, d1;
      a1 = a + b;   d1 = rotl(d ^ a1, 16);
      c1 = c + d1;  b1 = rotl(b ^ c1, 12);
      a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
      c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
      quarter = {a1, b1, c1, d1};
   endfunction

endpackage

### src/ccs_if.sv
// valid/ready channel interfaces for request, response and csr writes
// depends on ccs_pkg
interface ccs_req_if;
   logic               valid;
   logic               ready;
   ccs_pkg::req_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ccs_rsp_if;
   logic               valid;
   logic               ready;
   ccs_pkg::rsp_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ccs_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [ccs_pkg::CsrIdxWidth-1:0]      index;
   logic [ccs_pkg::CsrDataWidth-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/ccs_datapath.sv
// block function datapath: config registers, working state, keystream, output byte
// depends on ccs_pkg
module ccs_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ccs_pkg::CsrIdxWidth-1:0]   csr_idx,
   input  logic [ccs_pkg::CsrDataWidth-1:0]  csr_wdata,
   input  ccs_pkg::cmd_type                  cmd,
   input  ccs_pkg::req_type                  req_data,
   input  logic [ccs_pkg::ByteIdxWidth-1:0]  byte_idx,
   output ccs_pkg::rsp_type                  rsp_data
);

   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff, nonce_lo_ff;
   logic [31:0] nonce_hi_ff, start_ff, counter_ff;
   ccs_pkg::state_type init_ff, work_ff, ks_ff, init_in, round_out;
   ccs_pkg::rsp_type rsp_ff;
   logic [31:0] ks_word;
   logic [7:0]  ks_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0; key1_ff <= '0; key2_ff <= '0; key3_ff <= '0;
         nonce_lo_ff <= '0; nonce_hi_ff <= '0; start_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_idx)
            ccs_pkg::REG_KEY0:        key0_ff <= csr_wdata;
            ccs_pkg::REG_KEY1:        key1_ff <= csr_wdata;
            ccs_pkg::REG_KEY2:        key2_ff <= csr_wdata;
            ccs_pkg::REG_KEY3:        key3_ff <= csr_wdata;
            ccs_pkg::REG_NONCE_LOW:   nonce_lo_ff <= csr_wdata;
            ccs_pkg::REG_NONCE_HIGH:  nonce_hi_ff <= csr_wdata[31:0];
            ccs_pkg::REG_START_COUNT: start_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         counter_ff <= '0;
      else if (cmd.restart)
         counter_ff <= start_ff;
      else if (cmd.finish)
         counter_ff <= counter_ff + 32'd1;
   end

   always_comb begin
      init_in[0]  = ccs_pkg::SIGMA0;
      init_in[1]  = ccs_pkg::SIGMA1;
      init_in[2]  = ccs_pkg::SIGMA2;
      init_in[3]  = ccs_pkg::SIGMA3;
      init_in[4]  = key0_ff[31:0];  init_in[5]  = key0_ff[63:32];
      init_in[6]  = key1_ff[31:0];  init_in[7]  = key1_ff[63:32];
      init_in[8]  = key2_ff[31:0];  init_in[9]  = key2_ff[63:32];
      init_in[10] = key3_ff[31:0];  init_in[11] = key3_ff[63:32];
      init_in[12] = counter_ff;
      init_in[13] = nonce_lo_ff[31:0];
      init_in[14] = nonce_lo_ff[63:32];
      init_in[15] = nonce_hi_ff;
   end

   // four independent quarter rounds per cycle, column or diagonal
   always_comb begin
      round_out = work_ff;
      if (!cmd.diag) begin
         for (int i = 0; i < 4; i++)
            {round_out[i], round_out[4+i], round_out[8+i], round_out[12+i]} =
               ccs_pkg::quarter(work_ff[i], work_ff[4+i], work_ff[8+i], work_ff[12+i]);
      end else begin
         for (int i = 0; i < 4; i++)
            {round_out[i], round_out[4+((i+1)%4)], round_out[8+((i+2)%4)],
             round_out[12+((i+3)%4)]} =
               ccs_pkg::quarter(work_ff[i], work_ff[4+((i+1)%4)],
                                work_ff[8+((i+2)%4)], work_ff[12+((i+3)%4)]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_init) begin
         init_ff <= init_in;
         work_ff <= init_in;
      end else if (cmd.round) begin
         work_ff <= round_out;
      end
      if (cmd.finish)
         for (int i = 0; i < 16; i++)
            ks_ff[i] <= work_ff[i] + init_ff[i];
      if (cmd.take_byte)
         rsp_ff <= '{data_out: req_data.data_in ^ ks_byte, last_out: req_data.last_in};
   end

   assign ks_word  = ks_ff[byte_idx[ccs_pkg::ByteIdxWidth-1:2]];
   assign ks_byte  = ks_word[{byte_idx[1:0], 3'b000} +: 8];
   assign rsp_data = rsp_ff;

endmodule

### src/ccs_controller.sv
// sequencer: block generation rounds, byte position and the channel handshakes
// depends on ccs_pkg
module ccs_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  ccs_pkg::req_type                  req_data,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ccs_pkg::cmd_type                  cmd,
   output logic [ccs_pkg::ByteIdxWidth-1:0]  byte_idx
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ROUND  = 3'd1;
   localparam logic [2:0] ST_FINISH = 3'd2;
   localparam logic [2:0] ST_XOR    = 3'd3;

   logic [2:0] state_ff, state_in;
   logic [ccs_pkg::UsedWidth-1:0] used_ff, used_in;
   logic [ccs_pkg::RoundCntWidth-1:0] rnd_ff, rnd_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, need_block, out_free;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign need_block = req_data.restart || used_ff[ccs_pkg::UsedWidth-1];
   assign rsp_valid  = rsp_valid_ff;
   assign byte_idx   = used_ff[ccs_pkg::ByteIdxWidth-1:0];

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      rnd_in       = rnd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: if (accept) begin
            cmd.restart = req_data.restart;
            if (need_block) begin
               state_in = ST_ROUND;
               rnd_in   = '0;
            end else begin
               state_in = ST_XOR;
            end
         end
         ST_ROUND: begin
            cmd.round = (rnd_ff != '0);
            cmd.load_init = (rnd_ff == '0);
            cmd.diag  = !rnd_ff[0];
            rnd_in    = rnd_ff + 1'b1;
            if (rnd_ff == ccs_pkg::RoundCntWidth'(2 * ccs_pkg::DoubleRounds))
               state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            used_in    = '0;
            state_in   = ST_XOR;
         end
         ST_XOR: if (out_free) begin
            cmd.take_byte = 1'b1;
            rsp_valid_in  = 1'b1;
            used_in       = req_data.last_in ? ccs_pkg::UsedWidth'(ccs_pkg::BlockBytes)
                                             : used_ff + 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= ccs_pkg::UsedWidth'(ccs_pkg::BlockBytes);
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/chacha20_stream_cipher.sv
// chacha20 stream cipher, one byte per transfer, 20 rounds via one shared half-round unit
// a byte from a held block goes straight to the xor step; when a block is generated the steps are
// seed, 20 half rounds, final add, xor; a new byte is accepted only once the last one is xored
// the input byte is held in a register while the block is built or the result waits
// reset (synchronous): counter zero, no block held, config registers zero, no result pending
module chacha20_stream_cipher (
   input  logic        clock,
   input  logic        reset,
   ccs_req_if.sink     req,
   ccs_rsp_if.source   rsp,
   ccs_csr_if.sink     csr
);

   ccs_pkg::cmd_type cmd;
   ccs_pkg::req_type req_hold_ff;
   logic [ccs_pkg::ByteIdxWidth-1:0] byte_idx;
   logic req_ready_int, accept;

   assign csr.ready = 1'b1;
   assign req.ready = req_ready_int;
   assign accept    = req.valid && req_ready_int;

   always_ff @(posedge clock) begin
      if (accept)
         req_hold_ff <= req.payload;
   end

   ccs_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_data  (accept ? req.payload : req_hold_ff),
      .req_ready (req_ready_int),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .byte_idx  (byte_idx)
   );

   ccs_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr.valid),
      .csr_idx   (csr.index),
      .csr_wdata (csr.data),
      .cmd       (cmd),
      .req_data  (req_hold_ff),
      .byte_idx  (byte_idx),
      .rsp_data  (rsp.payload)
   );

   // a waiting result holds its valid and payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.payload)))
      else $error("pending result changed");

   // finish is a single-cycle step
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !cmd.finish)
      else $error("double finish");

   // restart only with an accepted item
   assert property (@(posedge clock) disable iff (reset)
      cmd.restart |-> accept)
      else $error("restart without transfer");

endmodule
